>>> hw/rtl/mtrp_pkg.sv
package mtrp_pkg;

    localparam int unsigned MAX_FILLERS = 40;
    localparam int unsigned MAX_PENDING = 16;

    localparam logic [30:0] MIN_PERIOD_US   = 31'd1000;
    localparam logic [30:0] PERIOD_DISABLED = 31'h7FFF_FFFF;
    localparam logic [30:0] DELAY_LIMIT     = 31'd65535;
    localparam logic signed [20:0] US_PER_SECOND = 21'sd1000000;

    localparam int unsigned FILL_W = $clog2(MAX_FILLERS + 1);
    localparam int unsigned PEND_W = 5;

    // step counter
    localparam int unsigned PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc STEP_WAIT   = 3'd0;
    localparam t_pc STEP_MUL    = 3'd1;
    localparam t_pc STEP_GAP    = 3'd2;
    localparam t_pc STEP_TEST   = 3'd3;
    localparam t_pc STEP_FILL   = 3'd4;
    localparam t_pc STEP_NEWSET = 3'd5;
    localparam t_pc STEP_NEW    = 3'd6;

    // datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_ACCEPT = 3'd0;
    localparam t_op OP_MUL    = 3'd1;
    localparam t_op OP_GAP    = 3'd2;
    localparam t_op OP_TEST   = 3'd3;
    localparam t_op OP_FILL   = 3'd4;
    localparam t_op OP_NEWSET = 3'd5;
    localparam t_op OP_NEW    = 3'd6;
    localparam t_op OP_NOP    = 3'd7;

    // jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_SEQ    = 3'd0;
    localparam t_cond C_ALW    = 3'd1;
    localparam t_cond C_NOFILL = 3'd2;
    localparam t_cond C_NOPEND = 3'd3;
    localparam t_cond C_DONE   = 3'd4;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic slot_free;
        logic no_fill;
        logic no_pend;
        logic last_copy;
    } t_stat;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctl;

endpackage

>>> hw/rtl/missed_tick_record_padder.sv
// Missed-tick record padder.
// Input channel (i_in_valid / o_in_stall) takes one handled tick word: timestamp,
// serial number, handling delay and pending tick count. Output channel
// (o_out_valid / i_out_stall) delivers record words, one per cycle at best,
// with o_last_of_run on the final record caused by a tick. The configuration
// channel (i_cfg_valid / o_cfg_ready) writes the expected period; it is
// always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this. A tick passes through a
// microcoded sequencer: accept, multiply, gap, then a test/filler loop of
// one test and one filler step per filler, a closing test, a setup step
// and one new-record step per copy. A tick gives at most 40 fillers and
// at most 16 copies. The first record is written to the output register
// by the first filler step, or by the first new-record step when there is
// no filler. The output register lets the sequencer run one record ahead
// of the receiver; while i_out_stall is high the word is held and the
// sequencer waits. No new tick is taken until the last record of the
// current tick is in the output register.
// Reset sets the period to its disabled value and clears the held state.
module missed_tick_record_padder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_tick_seconds,
    input  logic [19:0] i_tick_microseconds,
    input  logic [31:0] i_serial_number,
    input  logic [30:0] i_handling_delay_us,
    input  logic [4:0]  i_pending_ticks,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_record_serial,
    output logic [31:0] o_record_seconds,
    output logic [19:0] o_record_microseconds,
    output logic [15:0] o_record_delay_us,
    output logic        o_flag_repeated,
    output logic        o_flag_lost_excess,
    output logic        o_flag_multiple,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);
    import mtrp_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;

    logic [30:0] r_period;
    logic [31:0] r_prev_sec;
    logic [19:0] r_prev_usec;
    logic        r_have_prev;
    logic [31:0] r_held_serial;
    logic [15:0] r_held_delay;

    // working copy of the current tick
    logic [31:0] r_sec;
    logic [19:0] r_usec;
    logic [31:0] r_serial;
    logic [15:0] r_delay;
    logic [PEND_W-1:0] r_pend;
    logic [31:0] r_old_sec;
    logic [19:0] r_old_usec;
    logic        r_had_prev;
    logic signed [32:0] r_sdiff;
    logic signed [20:0] r_udiff;
    logic signed [53:0] r_prod;
    logic signed [33:0] r_gap;
    logic [FILL_W-1:0]  r_fill_cnt;
    logic [PEND_W-1:0]  r_copy;
    logic               r_lost;

    logic        r_out_valid;
    logic [31:0] r_o_serial;
    logic [31:0] r_o_sec;
    logic [19:0] r_o_usec;
    logic [15:0] r_o_delay;
    logic        r_o_rep;
    logic        r_o_lost;
    logic        r_o_mult;
    logic        r_o_last;

    logic               w_accept;
    logic               w_pad_en;
    logic [31:0]        w_thr;
    logic signed [33:0] w_thr_s;
    logic signed [33:0] w_gap_next;
    logic               w_over;
    logic               w_cnt_max;
    logic               w_fill_last;
    logic signed [53:0] w_prod;
    logic signed [54:0] w_sum;
    logic signed [31:0] w_gap_sat;
    logic [15:0]        w_delay_sat;
    logic [PEND_W-1:0]  w_pend_clamp;
    logic               w_slot_free;
    logic               w_emit;

    mtrp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;

    assign w_pad_en  = (r_period >= MIN_PERIOD_US) && (r_period != PERIOD_DISABLED);
    // floor(3p/2) = p + floor(p/2)
    assign w_thr     = {1'b0, r_period} + {2'b0, r_period[30:1]};
    assign w_thr_s   = $signed({2'b0, w_thr});
    assign w_over    = w_pad_en && (r_gap > w_thr_s);
    assign w_cnt_max = (r_fill_cnt == FILL_W'(MAX_FILLERS));
    assign w_gap_next  = r_gap - $signed({3'b0, r_period});
    assign w_fill_last = (r_pend == '0) &&
                         ((w_gap_next <= w_thr_s) ||
                          (r_fill_cnt + FILL_W'(1) == FILL_W'(MAX_FILLERS)));

    assign w_prod = r_sdiff * US_PER_SECOND;
    assign w_sum  = 55'(r_prod) + 55'(r_udiff);
    always_comb begin
        if (w_sum > 55'sh0_7FFF_FFFF) begin
            w_gap_sat = 32'sh7FFF_FFFF;
        end else if (w_sum < -55'sh0_8000_0000) begin
            w_gap_sat = 32'sh8000_0000;
        end else begin
            w_gap_sat = w_sum[31:0];
        end
    end

    assign w_delay_sat  = (i_handling_delay_us > DELAY_LIMIT) ? 16'hFFFF
                                                              : i_handling_delay_us[15:0];
    assign w_pend_clamp = (i_pending_ticks > PEND_W'(MAX_PENDING)) ? PEND_W'(MAX_PENDING)
                                                                   : i_pending_ticks;

    assign w_stat.in_valid  = i_in_valid;
    assign w_stat.slot_free = w_slot_free;
    assign w_stat.no_fill   = !w_over || w_cnt_max;
    assign w_stat.no_pend   = (r_pend == '0);
    assign w_stat.last_copy = (r_copy == r_pend - PEND_W'(1));

    assign w_emit = w_ctl.fire && ((w_ctl.op == OP_FILL) || (w_ctl.op == OP_NEW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_DISABLED;
            r_prev_sec    <= '0;
            r_prev_usec   <= '0;
            r_have_prev   <= 1'b0;
            r_held_serial <= '0;
            r_held_delay  <= '0;
            r_out_valid   <= 1'b0;
            r_fill_cnt    <= '0;
            r_copy        <= '0;
            r_lost        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctl.fire) begin
                case (w_ctl.op)
                    OP_ACCEPT: begin
                        r_prev_sec  <= i_tick_seconds;
                        r_prev_usec <= i_tick_microseconds;
                        r_have_prev <= 1'b1;
                    end
                    OP_GAP: begin
                        r_fill_cnt <= '0;
                        r_lost     <= 1'b0;
                    end
                    OP_TEST: begin
                        if (w_over && w_cnt_max) begin
                            r_lost <= 1'b1;
                        end
                    end
                    OP_FILL: begin
                        r_held_serial <= r_held_serial + 32'd1;
                        r_fill_cnt    <= r_fill_cnt + FILL_W'(1);
                    end
                    OP_NEWSET: begin
                        r_held_serial <= r_serial;
                        r_held_delay  <= r_delay;
                        r_copy        <= '0;
                    end
                    OP_NEW: begin
                        r_copy <= r_copy + PEND_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (w_ctl.fire) begin
            case (w_ctl.op)
                OP_ACCEPT: begin
                    r_sec      <= i_tick_seconds;
                    r_usec     <= i_tick_microseconds;
                    r_serial   <= i_serial_number;
                    r_delay    <= w_delay_sat;
                    r_pend     <= w_pend_clamp;
                    r_old_sec  <= r_prev_sec;
                    r_old_usec <= r_prev_usec;
                    r_had_prev <= r_have_prev;
                    r_sdiff    <= $signed({1'b0, i_tick_seconds}) - $signed({1'b0, r_prev_sec});
                    r_udiff    <= $signed({1'b0, i_tick_microseconds})
                                - $signed({1'b0, r_prev_usec});
                end
                OP_MUL: begin
                    r_prod <= w_prod;
                end
                OP_GAP: begin
                    r_gap <= r_had_prev ? 34'(w_gap_sat) : '0;
                end
                OP_FILL: begin
                    r_gap      <= w_gap_next;
                    r_o_serial <= r_held_serial + 32'd1;
                    r_o_sec    <= r_old_sec;
                    r_o_usec   <= r_old_usec;
                    r_o_delay  <= r_held_delay;
                    r_o_rep    <= 1'b1;
                    r_o_lost   <= 1'b0;
                    r_o_mult   <= 1'b0;
                    r_o_last   <= w_fill_last;
                end
                OP_NEW: begin
                    r_o_serial <= r_serial;
                    r_o_sec    <= r_sec;
                    r_o_usec   <= r_usec;
                    r_o_delay  <= r_delay;
                    r_o_rep    <= 1'b0;
                    r_o_lost   <= r_lost;
                    r_o_mult   <= (r_copy != '0);
                    r_o_last   <= w_stat.last_copy;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall            = (w_ctl.op != OP_ACCEPT);
    assign o_cfg_ready           = 1'b1;
    assign o_out_valid           = r_out_valid;
    assign o_record_serial       = r_o_serial;
    assign o_record_seconds      = r_o_sec;
    assign o_record_microseconds = r_o_usec;
    assign o_record_delay_us     = r_o_delay;
    assign o_flag_repeated       = r_o_rep;
    assign o_flag_lost_excess    = r_o_lost;
    assign o_flag_multiple       = r_o_mult;
    assign o_last_of_run         = r_o_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_cnt <= FILL_W'(MAX_FILLERS))
        else $error("filler count beyond limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("tick accepted while previous still in work");

    a_filler_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_rep |-> !r_o_mult && !r_o_lost)
        else $error("filler record carries new-record flags");

endmodule

>>> hw/rtl/mtrp_seq.sv
module mtrp_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtrp_pkg::t_stat i_stat,
    output mtrp_pkg::t_ctl  o_ctl
);
    import mtrp_pkg::*;

    t_pc  r_pc;
    t_pc  n_pc;
    t_uop w_uop;
    logic w_hold;
    logic w_take;

    // control store
    always_comb begin
        unique case (r_pc)
            STEP_WAIT:   w_uop = '{op: OP_ACCEPT, cond: C_SEQ,    target: STEP_WAIT};
            STEP_MUL:    w_uop = '{op: OP_MUL,    cond: C_SEQ,    target: STEP_WAIT};
            STEP_GAP:    w_uop = '{op: OP_GAP,    cond: C_SEQ,    target: STEP_WAIT};
            STEP_TEST:   w_uop = '{op: OP_TEST,   cond: C_NOFILL, target: STEP_NEWSET};
            STEP_FILL:   w_uop = '{op: OP_FILL,   cond: C_ALW,    target: STEP_TEST};
            STEP_NEWSET: w_uop = '{op: OP_NEWSET, cond: C_NOPEND, target: STEP_WAIT};
            STEP_NEW:    w_uop = '{op: OP_NEW,    cond: C_DONE,   target: STEP_WAIT};
            default:     w_uop = '{op: OP_NOP,    cond: C_ALW,    target: STEP_WAIT};
        endcase
    end

    // hold while the input is absent or the output slot is full
    always_comb begin
        unique case (w_uop.op) inside
            OP_ACCEPT:      w_hold = !i_stat.in_valid;
            OP_FILL,
            OP_NEW:         w_hold = !i_stat.slot_free;
            default:        w_hold = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_uop.cond)
            C_ALW:    w_take = 1'b1;
            C_NOFILL: w_take = i_stat.no_fill;
            C_NOPEND: w_take = i_stat.no_pend;
            C_DONE:   w_take = i_stat.last_copy;
            default:  w_take = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uop.target;
        end else if (w_uop.cond == C_DONE) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.op   = w_uop.op;
    assign o_ctl.fire = !w_hold;

endmodule
